@@ hdl/rope_tension_force_evaluator_defines.svh @@
// ---------------------------------------------------------------------------
// rope tension evaluator assertion macros
// shared property wrappers for the port-level checker
// ---------------------------------------------------------------------------
`ifndef ROPE_TENSION_FORCE_EVALUATOR_DEFINES_SVH
`define ROPE_TENSION_FORCE_EVALUATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RTFE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RTFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rtfe_pkg.sv @@
// ---------------------------------------------------------------------------
// rtfe_pkg
// shared types and codes of the rope tension evaluator
// ---------------------------------------------------------------------------
package rtfe_pkg;

  // verdict codes
  localparam logic [1:0] VERDICT_SLACK = 2'd0;
  localparam logic [1:0] VERDICT_PULL  = 2'd1;
  localparam logic [1:0] VERDICT_BREAK = 2'd2;

  // configuration register indexes
  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_SLACK_LEN    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STIFFNESS    = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DAMP_COEFF   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BREAK_SCALE  = 8'd3;
  // indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP_INDEX    = 8'hff;

  // pipeline layout
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 17;
  localparam int ST_DIFF    = 0;
  localparam int ST_SQ      = 1;
  localparam int ST_SUM     = 2;
  localparam int ST_SQRT0   = 3;
  localparam int ST_CHECK   = ST_SQRT0 + SQRT_STEPS;
  localparam int ST_DIV0    = ST_CHECK + 1;
  localparam int ST_PROD    = ST_DIV0 + DIV_STEPS;
  localparam int ST_SPEED   = ST_PROD + 1;
  localparam int ST_DAMP    = ST_SPEED + 1;
  localparam int ST_MAG     = ST_DAMP + 1;
  localparam int ST_FPROD   = ST_MAG + 1;
  localparam int ST_FINAL   = ST_FPROD + 1;
  localparam int NUM_STAGES = ST_FINAL + 1;

  typedef struct packed {
    logic signed [31:0] dx, dy, dz;
    logic [31:0]        mx, my, mz;
    logic signed [31:0] vx, vy, vz;
    logic [30:0]        rest, limit, strength;
    logic [63:0]        sq_x, sq_y, sq_z;
    logic [63:0]        rem;
    logic [63:0]        root;
    logic [32:0]        sep;
    logic [32:0]        ext;
    logic               done;
    logic [1:0]         verdict;
    logic [47:0]        drem_x, drem_y, drem_z;
    logic [16:0]        q_x, q_y, q_z;
    logic signed [17:0] dir_x, dir_y, dir_z;
    logic signed [49:0] p_x, p_y, p_z;
    logic [61:0]        el_prod, brk_prod;
    logic signed [31:0] speed;
    logic [45:0]        elastic, brk;
    logic signed [62:0] damp_prod;
    logic [30:0]        mag;
    logic signed [49:0] f_x, f_y, f_z;
    logic [31:0]        force_x, force_y, force_z;
  } work_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [31:0] force_x, force_y, force_z;
    logic [30:0] mag;
  } result_t;

endpackage

@@ hdl/rope_tension_force_evaluator.sv @@
// ---------------------------------------------------------------------------
// rope_tension_force_evaluator
// damped spring rope tension with stretch and strength break checks
// ---------------------------------------------------------------------------
// channel   direction  handshake                 payload
// s_axis    in         s_axis_tvalid/tready      one span request, 384-bit tdata
// m_axis    out        m_axis_tvalid/tready      one result, 128-bit tdata, tuser
// cfg       in         cfg_valid/cfg_ready       register index and value
//
// one request can enter each cycle while s_axis_tready is high
// the pipeline has 59 stages (3 input, 32 one-bit square root, 1 check, 17 divider,
// 6 product and scaling), the last feeding the output register
// rst is synchronous, clears all valid bits and resets the config registers
// a stalled output keeps the pipeline moving one more request into a skid
// entry; s_axis_tready drops only while that skid entry is full
// ---------------------------------------------------------------------------
module rope_tension_force_evaluator
  import rtfe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z, rel_vel_x,
  // rel_vel_y, rel_vel_z, rest_length, stretch_limit, span_strength, zero pad
  input  logic [383:0]           s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // force_x, force_y, force_z, force_magnitude, zero pad
  output logic [127:0]           m_axis_tdata,
  // verdict
  output logic [1:0]             m_axis_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  // config registers
  logic [30:0] slack_len, stiffness, damp_coeff, break_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      slack_len   <= '0;
      stiffness   <= 31'd65536;
      damp_coeff  <= '0;
      break_scale <= 31'd65536;
    end else if (cfg_valid) begin
      // writes beyond the last register are dropped
      if (cfg_index == REG_SLACK_LEN)   slack_len   <= cfg_data[30:0];
      if (cfg_index == REG_STIFFNESS)   stiffness   <= cfg_data[30:0];
      if (cfg_index == REG_DAMP_COEFF)  damp_coeff  <= cfg_data[30:0];
      if (cfg_index == REG_BREAK_SCALE) break_scale <= cfg_data[30:0];
    end
  end

  assign cfg_ready = 1'b1;

  // b - a saturated to 32 bits signed
  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] b,
                                                 input logic signed [31:0] a);
    logic signed [32:0] r;
    r = 33'(b) - 33'(a);
    if (r > 33'sd2147483647)       sub_sat = 32'sh7fffffff;
    else if (r < -33'sd2147483648) sub_sat = 32'sh80000000;
    else                           sub_sat = r[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  // pipeline
  work_t pipe      [NUM_STAGES];
  work_t pipe_next [NUM_STAGES];
  logic  vld       [NUM_STAGES];
  logic  en;

  // output register plus one skid entry
  result_t out_res, skid_res, push_res;
  logic    out_valid, skid_valid;

  assign en            = !skid_valid;
  assign s_axis_tready = en;

  always_comb begin
    logic [63:0]        bitv, t;
    logic [49:0]        dv;
    logic [30:0]        ea;
    logic signed [51:0] dot;
    logic signed [35:0] dq;
    logic signed [46:0] dmq;
    logic signed [47:0] m;
    logic [31:0]        thr;

    pipe_next[0] = pipe[0];
    for (int s = 1; s < NUM_STAGES; s++) pipe_next[s] = pipe[s-1];

    // difference and magnitudes
    pipe_next[ST_DIFF].dx       = sub_sat(s_axis_tdata[127:96], s_axis_tdata[31:0]);
    pipe_next[ST_DIFF].dy       = sub_sat(s_axis_tdata[159:128], s_axis_tdata[63:32]);
    pipe_next[ST_DIFF].dz       = sub_sat(s_axis_tdata[191:160], s_axis_tdata[95:64]);
    pipe_next[ST_DIFF].mx       = abs32(pipe_next[ST_DIFF].dx);
    pipe_next[ST_DIFF].my       = abs32(pipe_next[ST_DIFF].dy);
    pipe_next[ST_DIFF].mz       = abs32(pipe_next[ST_DIFF].dz);
    pipe_next[ST_DIFF].vx       = s_axis_tdata[223:192];
    pipe_next[ST_DIFF].vy       = s_axis_tdata[255:224];
    pipe_next[ST_DIFF].vz       = s_axis_tdata[287:256];
    pipe_next[ST_DIFF].rest     = s_axis_tdata[318:288];
    pipe_next[ST_DIFF].limit    = s_axis_tdata[349:319];
    pipe_next[ST_DIFF].strength = s_axis_tdata[380:350];

    // squares
    pipe_next[ST_SQ].sq_x = 64'(pipe[ST_SQ-1].mx) * 64'(pipe[ST_SQ-1].mx);
    pipe_next[ST_SQ].sq_y = 64'(pipe[ST_SQ-1].my) * 64'(pipe[ST_SQ-1].my);
    pipe_next[ST_SQ].sq_z = 64'(pipe[ST_SQ-1].mz) * 64'(pipe[ST_SQ-1].mz);

    // sum of squares, cannot wrap
    pipe_next[ST_SUM].rem  = pipe[ST_SUM-1].sq_x + pipe[ST_SUM-1].sq_y + pipe[ST_SUM-1].sq_z;
    pipe_next[ST_SUM].root = '0;

    // one result bit per stage
    for (int j = 0; j < SQRT_STEPS; j++) begin
      bitv = 64'd1 << (62 - 2 * j);
      t    = pipe[ST_SQRT0+j-1].root + bitv;
      if (pipe[ST_SQRT0+j-1].rem >= t) begin
        pipe_next[ST_SQRT0+j].rem  = pipe[ST_SQRT0+j-1].rem - t;
        pipe_next[ST_SQRT0+j].root = (pipe[ST_SQRT0+j-1].root >> 1) + bitv;
      end else begin
        pipe_next[ST_SQRT0+j].root = pipe[ST_SQRT0+j-1].root >> 1;
      end
    end

    // slack and overstretch
    pipe_next[ST_CHECK].sep     = pipe[ST_CHECK-1].root[32:0];
    thr = 32'(pipe[ST_CHECK-1].rest) + 32'(slack_len);
    pipe_next[ST_CHECK].ext     = pipe[ST_CHECK-1].root[32:0] - 33'(pipe[ST_CHECK-1].rest);
    pipe_next[ST_CHECK].done    = 1'b0;
    pipe_next[ST_CHECK].verdict = VERDICT_PULL;
    if (pipe[ST_CHECK-1].root[32:0] <= 33'(thr)) begin
      pipe_next[ST_CHECK].done    = 1'b1;
      pipe_next[ST_CHECK].verdict = VERDICT_SLACK;
    end else if (pipe_next[ST_CHECK].ext > 33'(pipe[ST_CHECK-1].limit)) begin
      pipe_next[ST_CHECK].done    = 1'b1;
      pipe_next[ST_CHECK].verdict = VERDICT_BREAK;
    end
    pipe_next[ST_CHECK].drem_x = {pipe[ST_CHECK-1].mx, 16'd0};
    pipe_next[ST_CHECK].drem_y = {pipe[ST_CHECK-1].my, 16'd0};
    pipe_next[ST_CHECK].drem_z = {pipe[ST_CHECK-1].mz, 16'd0};
    pipe_next[ST_CHECK].q_x    = '0;
    pipe_next[ST_CHECK].q_y    = '0;
    pipe_next[ST_CHECK].q_z    = '0;

    // restoring divide |d| * 65536 / sep, one quotient bit per stage
    for (int j = 0; j < DIV_STEPS; j++) begin
      dv = 50'(pipe[ST_DIV0+j-1].sep) << (DIV_STEPS - 1 - j);
      if (50'(pipe[ST_DIV0+j-1].drem_x) >= dv) begin
        pipe_next[ST_DIV0+j].drem_x = pipe[ST_DIV0+j-1].drem_x - dv[47:0];
        pipe_next[ST_DIV0+j].q_x[DIV_STEPS-1-j] = 1'b1;
      end
      if (50'(pipe[ST_DIV0+j-1].drem_y) >= dv) begin
        pipe_next[ST_DIV0+j].drem_y = pipe[ST_DIV0+j-1].drem_y - dv[47:0];
        pipe_next[ST_DIV0+j].q_y[DIV_STEPS-1-j] = 1'b1;
      end
      if (50'(pipe[ST_DIV0+j-1].drem_z) >= dv) begin
        pipe_next[ST_DIV0+j].drem_z = pipe[ST_DIV0+j-1].drem_z - dv[47:0];
        pipe_next[ST_DIV0+j].q_z[DIV_STEPS-1-j] = 1'b1;
      end
    end

    // direction sign, dot products, elastic and breaking products
    pipe_next[ST_PROD].dir_x = pipe[ST_PROD-1].dx[31] ? -$signed({1'b0, pipe[ST_PROD-1].q_x})
                                                      : $signed({1'b0, pipe[ST_PROD-1].q_x});
    pipe_next[ST_PROD].dir_y = pipe[ST_PROD-1].dy[31] ? -$signed({1'b0, pipe[ST_PROD-1].q_y})
                                                      : $signed({1'b0, pipe[ST_PROD-1].q_y});
    pipe_next[ST_PROD].dir_z = pipe[ST_PROD-1].dz[31] ? -$signed({1'b0, pipe[ST_PROD-1].q_z})
                                                      : $signed({1'b0, pipe[ST_PROD-1].q_z});
    pipe_next[ST_PROD].p_x = 50'(pipe[ST_PROD-1].vx) * 50'(pipe_next[ST_PROD].dir_x);
    pipe_next[ST_PROD].p_y = 50'(pipe[ST_PROD-1].vy) * 50'(pipe_next[ST_PROD].dir_y);
    pipe_next[ST_PROD].p_z = 50'(pipe[ST_PROD-1].vz) * 50'(pipe_next[ST_PROD].dir_z);
    ea = pipe[ST_PROD-1].ext[30:0] - slack_len;
    pipe_next[ST_PROD].el_prod  = 62'(ea) * 62'(stiffness);
    pipe_next[ST_PROD].brk_prod = 62'(pipe[ST_PROD-1].strength) * 62'(break_scale);

    // separating speed and strength break
    dot = 52'(pipe[ST_SPEED-1].p_x) + 52'(pipe[ST_SPEED-1].p_y) + 52'(pipe[ST_SPEED-1].p_z);
    dq  = 36'((dot + (dot[51] ? 52'sd65535 : 52'sd0)) >>> 16);
    if (dq > 36'sd2147483647)       pipe_next[ST_SPEED].speed = 32'sh7fffffff;
    else if (dq < -36'sd2147483648) pipe_next[ST_SPEED].speed = 32'sh80000000;
    else                            pipe_next[ST_SPEED].speed = dq[31:0];
    pipe_next[ST_SPEED].elastic = pipe[ST_SPEED-1].el_prod[61:16];
    pipe_next[ST_SPEED].brk     = pipe[ST_SPEED-1].brk_prod[61:16];
    if (!pipe[ST_SPEED-1].done &&
        pipe_next[ST_SPEED].elastic >= pipe_next[ST_SPEED].brk) begin
      pipe_next[ST_SPEED].done    = 1'b1;
      pipe_next[ST_SPEED].verdict = VERDICT_BREAK;
    end

    // damping product
    pipe_next[ST_DAMP].damp_prod = 63'(pipe[ST_DAMP-1].speed) *
                                   $signed({32'd0, damp_coeff});

    // magnitude, clamped to [0, brk] and 31 bits
    dmq = 47'((pipe[ST_MAG-1].damp_prod +
               (pipe[ST_MAG-1].damp_prod[62] ? 63'sd65535 : 63'sd0)) >>> 16);
    m   = $signed({2'b0, pipe[ST_MAG-1].elastic}) + 48'(dmq);
    if (m < 48'sd0)                                     m = '0;
    else if (m > $signed({2'b0, pipe[ST_MAG-1].brk}))   m = $signed({2'b0, pipe[ST_MAG-1].brk});
    if (m > 48'sd2147483647)                            m = 48'sd2147483647;
    pipe_next[ST_MAG].mag = m[30:0];

    // force products
    pipe_next[ST_FPROD].f_x = 50'(pipe[ST_FPROD-1].dir_x) * $signed({19'd0, pipe[ST_FPROD-1].mag});
    pipe_next[ST_FPROD].f_y = 50'(pipe[ST_FPROD-1].dir_y) * $signed({19'd0, pipe[ST_FPROD-1].mag});
    pipe_next[ST_FPROD].f_z = 50'(pipe[ST_FPROD-1].dir_z) * $signed({19'd0, pipe[ST_FPROD-1].mag});

    // scale back, zero unless pulling
    pipe_next[ST_FINAL].force_x = 32'((pipe[ST_FINAL-1].f_x +
                                 (pipe[ST_FINAL-1].f_x[49] ? 50'sd65535 : 50'sd0)) >>> 16);
    pipe_next[ST_FINAL].force_y = 32'((pipe[ST_FINAL-1].f_y +
                                 (pipe[ST_FINAL-1].f_y[49] ? 50'sd65535 : 50'sd0)) >>> 16);
    pipe_next[ST_FINAL].force_z = 32'((pipe[ST_FINAL-1].f_z +
                                 (pipe[ST_FINAL-1].f_z[49] ? 50'sd65535 : 50'sd0)) >>> 16);
    if (pipe[ST_FINAL-1].done) begin
      pipe_next[ST_FINAL].force_x = '0;
      pipe_next[ST_FINAL].force_y = '0;
      pipe_next[ST_FINAL].force_z = '0;
      pipe_next[ST_FINAL].mag     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NUM_STAGES; s++) pipe[s] <= pipe_next[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_STAGES; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
      for (int s = 1; s < NUM_STAGES; s++) vld[s] <= vld[s-1];
    end
  end

  // result leaving the last stage
  assign push_res.verdict = pipe[ST_FINAL].verdict;
  assign push_res.force_x = pipe[ST_FINAL].force_x;
  assign push_res.force_y = pipe[ST_FINAL].force_y;
  assign push_res.force_z = pipe[ST_FINAL].force_z;
  assign push_res.mag     = pipe[ST_FINAL].mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_axis_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (vld[ST_FINAL]) begin
      if (out_valid && !m_axis_tready) skid_valid <= 1'b1;
      else                             out_valid  <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_axis_tready) out_res <= skid_res;
    end else if (vld[ST_FINAL]) begin
      if (out_valid && !m_axis_tready) skid_res <= push_res;
      else                             out_res  <= push_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.verdict;
  assign m_axis_tdata  = {1'b0, out_res.mag, out_res.force_z, out_res.force_y,
                          out_res.force_x};

endmodule

@@ hdl/rtfe_checker.sv @@
// ---------------------------------------------------------------------------
// rtfe_checker
// port-level checks of the rope tension evaluator
// ---------------------------------------------------------------------------
`include "rope_tension_force_evaluator_defines.svh"

module rtfe_checker
  import rtfe_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // stalled result holds
  `RTFE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // no unused verdict code
  `RTFE_ASSERT_SAME(a_verdict_code, m_axis_tvalid, m_axis_tuser <= VERDICT_BREAK, "bad verdict")

  // slack and break carry no force
  `RTFE_ASSERT_SAME(a_zero_force, m_axis_tvalid && m_axis_tuser != VERDICT_PULL, m_axis_tdata == '0, "force on non-pulling result")

  // input only blocks behind a waiting result
  `RTFE_ASSERT_SAME(a_ready_block, !s_axis_tready, m_axis_tvalid, "input blocked with no result waiting")

endmodule

bind rope_tension_force_evaluator rtfe_checker u_rtfe_checker (.*);
